// File: rtl/prim_mst_pkg.sv
// Shared types and constants for the Prim spanning tree block.
package prim_mst_pkg;

  localparam int unsigned VCW = 7;

  localparam logic [1:0] MODE_CLEAR   = 2'd0;
  localparam logic [1:0] MODE_ADD     = 2'd1;
  localparam logic [1:0] MODE_COMPUTE = 2'd2;

  localparam logic [31:0] ABSENT = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ST_TREE_EDGE = 2'd0,
    ST_NO_TREE   = 2'd1,
    ST_REJECT    = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]     mode;
    logic [VCW-1:0] edge_from;
    logic [VCW-1:0] edge_to;
    logic [30:0]    edge_weight;
  } req_t;

  typedef struct packed {
    status_e        status;
    logic [VCW-1:0] parent_vertex;
    logic [VCW-1:0] child_vertex;
    logic           last;
  } res_t;

endpackage

// File: rtl/prim_mst_pair_ram.sv
// Pair weight store: one write port, one registered read port.
module prim_mst_pair_ram #(
  parameter int unsigned DEPTH = 2016,
  parameter int unsigned AW    = 11,
  parameter int unsigned DW    = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: rtl/prim_minimum_spanning_tree.sv
// Top level: Prim minimum spanning tree over a triangular pair weight store.
//
// Use: write vertex_count through cfg_we_i/cfg_data_i while busy_o is low.
// An item transfers at a clock edge with start_i high and busy_o low.
// Add edge: a bad vertex gives a reject result the next cycle,
// a self-loop or a good edge gives none. The pair store takes the write.
// Clear: busy while it writes all MAX_VERTICES*(MAX_VERTICES-1)/2 store entries
// (2016 by default), one store entry per cycle; the same pass runs after
// reset before the first item is taken.
// Compute: each Prim round scans vertices 1..N-1 through the pair store
// and vertex store read ports, at most N rounds;
// then N-1 tree results come out on consecutive cycles in order of child,
// or one status result. A single vertex gives one result the next cycle.
// Each result shows on result_o for one cycle with result_valid_o high;
// the receiver cannot stall, so results are never held.
module prim_minimum_spanning_tree #(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [prim_mst_pkg::VCW-1:0]      cfg_data_i,
  input  logic                              start_i,
  input  prim_mst_pkg::req_t                req_i,
  output logic                              busy_o,
  output logic                              result_valid_o,
  output prim_mst_pkg::res_t                result_o
);

  localparam int unsigned PAIR_COUNT = (MAX_VERTICES * (MAX_VERTICES - 1)) / 2;
  localparam int unsigned AW = $clog2(PAIR_COUNT + 1);
  localparam int unsigned VW = $clog2(MAX_VERTICES);
  localparam int unsigned SW = 2 * VW + 2;
  localparam int unsigned VCW = prim_mst_pkg::VCW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLR   = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_PICK  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;
  localparam logic [2:0] S_FLUSH = 3'd6;

  typedef struct packed {
    logic [31:0]   weight;
    logic [VW-1:0] source;
  } vert_t;

  function automatic logic [AW-1:0] slot(input logic [VW-1:0] a, input logic [VW-1:0] b);
    logic [SW-1:0] lo;
    logic [SW-1:0] hi;
    logic [SW-1:0] s;
    lo = (a < b) ? SW'(a) : SW'(b);
    hi = (a < b) ? SW'(b) : SW'(a);
    s  = lo * SW'(MAX_VERTICES) - ((lo * (lo + SW'(1))) >> 1) + hi - lo - SW'(1);
    return AW'(s);
  endfunction

  logic [2:0]            state_q, state_d;
  logic [VCW-1:0]        vcount_q;
  logic [VCW-1:0]        n_live;
  logic [AW-1:0]         clr_q;
  logic [VW-1:0]         v_q, w_q, pick_q, p_w_q, oi_q, o_i_q;
  logic [31:0]           pick_wt_q;
  logic [VCW-1:0]        added_q;
  logic [MAX_VERTICES-1:0] in_tree_q, reached_q;
  logic                  p_valid_q, o_valid_q;
  logic                  result_valid_q;
  prim_mst_pkg::res_t    result_q;

  logic                  acc, edge_bad, edge_wr, upd, better, clr_last, scan_last, out_last;
  logic [VW-1:0]         e_from, e_to;
  logic [AW-1:0]         pw_waddr;
  logic [31:0]           pw_wdata, pair_rd, cur_wt, new_wt;
  logic                  pw_we;

  vert_t                 vmem [MAX_VERTICES];
  vert_t                 vrd_q;
  logic [VW-1:0]         v_raddr;

  assign n_live = (vcount_q == '0) ? VCW'(1) :
                  (vcount_q > VCW'(MAX_VERTICES)) ? VCW'(MAX_VERTICES) : vcount_q;

  assign acc      = start_i && (state_q == S_IDLE);
  assign edge_bad = (req_i.edge_from == '0) || (req_i.edge_to == '0) ||
                    (req_i.edge_from > n_live) || (req_i.edge_to > n_live);
  assign e_from   = VW'(req_i.edge_from - VCW'(1));
  assign e_to     = VW'(req_i.edge_to - VCW'(1));
  assign edge_wr  = acc && (req_i.mode == prim_mst_pkg::MODE_ADD) && !edge_bad &&
                    (req_i.edge_from != req_i.edge_to);

  assign clr_last  = (clr_q == AW'(PAIR_COUNT - 1));
  assign scan_last = (w_q == VW'(n_live - VCW'(1)));
  assign out_last  = (oi_q == VW'(n_live - VCW'(1)));

  assign pw_we    = (state_q == S_CLR) || edge_wr;
  assign pw_waddr = (state_q == S_CLR) ? clr_q : slot(e_from, e_to);
  assign pw_wdata = (state_q == S_CLR) ? prim_mst_pkg::ABSENT : {1'b0, req_i.edge_weight};

  prim_mst_pair_ram #(
    .DEPTH (PAIR_COUNT),
    .AW    (AW),
    .DW    (32)
  ) u_pair_ram (
    .clk_i   (clk_i),
    .we_i    (pw_we),
    .waddr_i (pw_waddr),
    .wdata_i (pw_wdata),
    .raddr_i (slot(v_q, w_q)),
    .rdata_o (pair_rd)
  );

  assign cur_wt = reached_q[p_w_q] ? vrd_q.weight : prim_mst_pkg::ABSENT;
  assign upd    = p_valid_q && !in_tree_q[p_w_q] && (pair_rd != prim_mst_pkg::ABSENT) &&
                  (pair_rd < cur_wt);
  assign new_wt = upd ? pair_rd : cur_wt;
  assign better = p_valid_q && !in_tree_q[p_w_q] && (new_wt < pick_wt_q);

  assign v_raddr = (state_q == S_OUT) ? oi_q : w_q;

  always_ff @(posedge clk_i) begin
    if (upd) begin
      vmem[p_w_q] <= '{weight: pair_rd, source: v_q};
    end
    vrd_q <= vmem[v_raddr];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (acc && req_i.mode == prim_mst_pkg::MODE_CLEAR) begin
          state_d = S_CLR;
        end else if (acc && req_i.mode == prim_mst_pkg::MODE_COMPUTE &&
                     n_live != VCW'(1)) begin
          state_d = S_SCAN;
        end
      end
      S_CLR:   if (clr_last) state_d = S_IDLE;
      S_SCAN:  if (scan_last) state_d = S_DRAIN;
      S_DRAIN: state_d = S_PICK;
      S_PICK: begin
        if (pick_q != '0) begin
          state_d = S_SCAN;
        end else if (added_q == n_live - VCW'(1)) begin
          state_d = S_OUT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_OUT:   if (out_last) state_d = S_FLUSH;
      S_FLUSH: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLR;
      vcount_q       <= VCW'(1);
      clr_q          <= '0;
      v_q            <= '0;
      w_q            <= '0;
      pick_q         <= '0;
      pick_wt_q      <= prim_mst_pkg::ABSENT;
      p_w_q          <= '0;
      oi_q           <= '0;
      o_i_q          <= '0;
      added_q        <= '0;
      in_tree_q      <= '0;
      reached_q      <= '0;
      p_valid_q      <= 1'b0;
      o_valid_q      <= 1'b0;
      result_valid_q <= 1'b0;
      result_q       <= '0;
    end else begin
      state_q        <= state_d;
      p_valid_q      <= 1'b0;
      o_valid_q      <= 1'b0;
      result_valid_q <= 1'b0;
      if (cfg_we_i) begin
        vcount_q <= cfg_data_i;
      end

      if (state_q == S_CLR) begin
        clr_q <= clr_last ? '0 : clr_q + AW'(1);
      end

      if (acc && req_i.mode == prim_mst_pkg::MODE_ADD && edge_bad) begin
        result_valid_q <= 1'b1;
        result_q       <= '{status: prim_mst_pkg::ST_REJECT, parent_vertex: '0,
                            child_vertex: '0, last: 1'b1};
      end
      if (acc && req_i.mode == prim_mst_pkg::MODE_COMPUTE) begin
        if (n_live == VCW'(1)) begin
          result_valid_q <= 1'b1;
          result_q       <= '{status: prim_mst_pkg::ST_EMPTY, parent_vertex: '0,
                              child_vertex: '0, last: 1'b1};
        end else begin
          in_tree_q <= '0;
          reached_q <= '0;
          added_q   <= '0;
          v_q       <= '0;
          w_q       <= VW'(1);
          pick_q    <= '0;
          pick_wt_q <= prim_mst_pkg::ABSENT;
        end
      end

      if (state_q == S_SCAN) begin
        p_valid_q <= 1'b1;
        p_w_q     <= w_q;
        w_q       <= w_q + VW'(1);
      end
      if (upd) begin
        reached_q[p_w_q] <= 1'b1;
      end
      if (better) begin
        pick_q    <= p_w_q;
        pick_wt_q <= new_wt;
      end

      if (state_q == S_PICK) begin
        if (pick_q != '0) begin
          in_tree_q[pick_q] <= 1'b1;
          added_q           <= added_q + VCW'(1);
          v_q               <= pick_q;
          pick_q            <= '0;
          pick_wt_q         <= prim_mst_pkg::ABSENT;
          w_q               <= VW'(1);
        end else if (added_q == n_live - VCW'(1)) begin
          oi_q <= VW'(1);
        end else begin
          result_valid_q <= 1'b1;
          result_q       <= '{status: prim_mst_pkg::ST_NO_TREE, parent_vertex: '0,
                              child_vertex: '0, last: 1'b1};
        end
      end

      if (state_q == S_OUT) begin
        o_valid_q <= 1'b1;
        o_i_q     <= oi_q;
        oi_q      <= oi_q + VW'(1);
      end
      if (o_valid_q) begin
        result_valid_q <= 1'b1;
        result_q       <= '{status: prim_mst_pkg::ST_TREE_EDGE,
                            parent_vertex: VCW'(vrd_q.source) + VCW'(1),
                            child_vertex: VCW'(o_i_q) + VCW'(1),
                            last: (VCW'(o_i_q) == n_live - VCW'(1))};
      end
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule

// File: rtl/prim_mst_chk.sv
// Port-level checker for the Prim spanning tree block, with its bind.
module prim_mst_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input prim_mst_pkg::req_t req_i,
  input logic               busy_o,
  input logic               result_valid_o,
  input prim_mst_pkg::res_t result_o
);

  a_reject_from_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.status == prim_mst_pkg::ST_REJECT) |->
      $past(start_i && !busy_o && req_i.mode == prim_mst_pkg::MODE_ADD))
    else $error("reject transfer without an add item");

  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && req_i.mode == prim_mst_pkg::MODE_CLEAR) |=> busy_o)
    else $error("clear did not start the store sweep");

  a_tree_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.last) |=>
      (result_valid_o && result_o.status == prim_mst_pkg::ST_TREE_EDGE))
    else $error("tree result burst broken");

  a_child_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.last) |=>
      (result_o.child_vertex == $past(result_o.child_vertex) + 7'd1))
    else $error("tree results out of child order");

endmodule

bind prim_minimum_spanning_tree prim_mst_chk u_prim_mst_chk (.*);
